// ===== rtl/core/mcfre_pkg.sv =====
// ---------------------------------------------------------------------------
// mcfre_pkg: shared types and constants of the fractional-rate emitter.
// Holds status codes, action codes and the command passed from front to back.
// ---------------------------------------------------------------------------
package mcfre_pkg;

  localparam int unsigned MaxPartW = 21;
  localparam int unsigned CntCfgW  = 5;
  localparam int unsigned SlotW    = 4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_CAPACITY = 2'd2
  } status_e;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_STEP = 1'b1
  } action_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_MAX_PART = 2'd0,
    REG_PPF      = 2'd1,
    REG_EMIT_CNT = 2'd2
  } cfg_reg_e;

  // Input item.
  typedef struct packed {
    logic [0:0]          action;
    logic [SlotW-1:0]    slot;
    logic [31:0]         emitter_id;
    logic [31:0]         start_at;
    logic [31:0]         stop_at;
    logic [31:0]         flow;
    logic [31:0]         step_number;
    logic [MaxPartW-1:0] active_count;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]          status;
    logic [31:0]         source_id;
    logic [MaxPartW-1:0] particle_count;
    logic [63:0]         first_particle;
    logic                last;
  } out_item_t;

  // Back-end state machine.
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD_CHK,
    BK_LOAD_MUL,
    BK_STEP_ACC,
    BK_STEP_CHK,
    BK_STEP_EMIT,
    BK_DONE
  } bk_state_e;

endpackage

// ===== rtl/core/mcfre_if.sv =====
// ---------------------------------------------------------------------------
// mcfre_if: valid/ready channel carrying one payload of a given type.
// Used for both the input items and the result items.
// ---------------------------------------------------------------------------
interface mcfre_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/multi_channel_fractional_rate_emitter_core.sv =====
// A load walks every slot to check its id; a failed check ends it early.
// A step walks the slots in use twice: one pass accumulates, one emits.
// An input transfer is registered in the queue before the back end sees it; result stalls hold the back end.
// One item is executed at a time; a two-entry queue takes new items meanwhile.
// Reset is asynchronous and active low; the table contents are undefined until loaded.
// ---------------------------------------------------------------------------
// multi_channel_fractional_rate_emitter_core: fractional-rate particle emitter.
// Front queue, back-end executor and configuration registers.
// ---------------------------------------------------------------------------
module multi_channel_fractional_rate_emitter_core #(
  parameter int unsigned MAX_EMITTERS  = 16,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned COUNT_BITS    = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  mcfre_if.sink       in_if,
  mcfre_if.source     out_if
);
  import mcfre_pkg::*;

  logic [MaxPartW-1:0] max_part_q;
  logic [31:0]         ppf_q;
  logic [CntCfgW-1:0]  ecount_q;
  logic                cmd_valid, cmd_pop;
  in_item_t            cmd_data;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_part_q <= MaxPartW'(65536);
      ppf_q      <= '0;
      ecount_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_PART: max_part_q <= cfg_data_i[MaxPartW-1:0];
        REG_PPF:      ppf_q      <= cfg_data_i;
        REG_EMIT_CNT: ecount_q   <= cfg_data_i[CntCfgW-1:0];
        default: ;
      endcase
    end
  end

  mcfre_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .in_data_i   (in_if.data),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_data_o  (cmd_data)
  );

  mcfre_back #(
    .MAX_EMITTERS(MAX_EMITTERS), .FRACTION_BITS(FRACTION_BITS), .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk_i, .rst_ni,
    .max_particles_i      (max_part_q),
    .particles_per_flow_i (ppf_q),
    .emitter_count_i      (ecount_q),
    .cmd_valid_i          (cmd_valid),
    .cmd_pop_o            (cmd_pop),
    .cmd_data_i           (cmd_data),
    .out_valid_o          (out_if.valid),
    .out_ready_i          (out_if.ready),
    .out_data_o           (out_if.data)
  );
endmodule

// ===== rtl/core/mcfre_front.sv =====
// ---------------------------------------------------------------------------
// mcfre_front: input stage and command queue.
// Accepts input items and holds up to two of them for the back end.
// ---------------------------------------------------------------------------
module mcfre_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mcfre_pkg::in_item_t in_data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_pop_i,
  output mcfre_pkg::in_item_t cmd_data_o
);
  import mcfre_pkg::*;

  in_item_t   buf_q [2];
  logic [0:0] wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign push        = in_valid_i && in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_data_o  = buf_q[rd_q];

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_data_i;
  end
endmodule

// ===== rtl/core/mcfre_back.sv =====
// ---------------------------------------------------------------------------
// mcfre_back: executes loads and steps against the emitter table.
// A load checks ids one slot per cycle; a step walks the slots twice.
// ---------------------------------------------------------------------------
module mcfre_back #(
  parameter int unsigned MAX_EMITTERS  = 16,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned COUNT_BITS    = 20
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [mcfre_pkg::MaxPartW-1:0] max_particles_i,
  input  logic [31:0]         particles_per_flow_i,
  input  logic [mcfre_pkg::CntCfgW-1:0]  emitter_count_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  mcfre_pkg::in_item_t cmd_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mcfre_pkg::out_item_t out_data_o
);
  import mcfre_pkg::*;

  localparam int unsigned RateW = COUNT_BITS + FRACTION_BITS;
  localparam int unsigned IdxW  = (MAX_EMITTERS > 1) ? $clog2(MAX_EMITTERS) : 1;
  localparam int unsigned WalkW = $clog2(MAX_EMITTERS + 1);
  localparam int unsigned CW    = COUNT_BITS + 1;
  localparam int unsigned TotW  = CW + WalkW;
  localparam logic [RateW-1:0] RateMax = '1;

  // Table storage.
  logic [31:0]              id_q    [MAX_EMITTERS];
  logic [31:0]              start_q [MAX_EMITTERS];
  logic [31:0]              stop_q  [MAX_EMITTERS];
  logic [RateW-1:0]         rate_q  [MAX_EMITTERS];
  logic [FRACTION_BITS-1:0] carry_q [MAX_EMITTERS];
  logic [FRACTION_BITS-1:0] newc_q  [MAX_EMITTERS];
  logic [CW-1:0]            cnt_q   [MAX_EMITTERS];
  logic [MAX_EMITTERS-1:0]  written_q;
  logic [MAX_EMITTERS-1:0]  nz_q;

  bk_state_e          state_q, state_d;
  logic [WalkW-1:0]   idx_q;
  logic               err_q;
  logic [1:0]         errst_q;
  logic [TotW-1:0]    total_q;
  logic               started_q;
  logic [31:0]        exp_q;
  logic [63:0]        next_q;
  logic [63:0]        prod_q;
  logic               emitted_q;
  out_item_t          out_q;
  logic               ovalid_q;

  in_item_t           cmd;
  logic [IdxW-1:0]    ix;
  logic [IdxW-1:0]    sl;
  logic               slot_ok;
  logic               out_free;
  logic               walk_end;
  logic               active;
  logic [FRACTION_BITS:0] fsum;
  logic [FRACTION_BITS-1:0] cin;
  logic [CW-1:0]      cnt_now;
  logic               pre_bad;
  logic               unwritten;
  logic               more_after;
  logic               final_out;
  logic [MaxPartW-1:0] free_cap;
  logic [63:0]        id_room;
  logic [RateW-1:0]   rate_new;

  assign cmd      = cmd_data_i;
  assign ix       = idx_q[IdxW-1:0];
  assign sl       = IdxW'(cmd.slot);
  assign slot_ok  = ({{(32-SlotW){1'b0}}, cmd.slot} < 32'(MAX_EMITTERS));
  assign out_free = !ovalid_q || out_ready_i;
  assign walk_end = (idx_q == WalkW'(MAX_EMITTERS - 1)) ||
                    ({{(32-WalkW){1'b0}}, idx_q} + 32'd1 >= 32'(emitter_count_i));
  assign active   = (cmd.step_number >= start_q[ix]) && (cmd.step_number < stop_q[ix]);
  assign cin      = started_q ? carry_q[ix] : '0;
  assign fsum     = {1'b0, rate_q[ix][FRACTION_BITS-1:0]} + {1'b0, cin};
  assign cnt_now  = CW'(rate_q[ix][RateW-1:FRACTION_BITS]) + CW'(fsum[FRACTION_BITS]);
  assign pre_bad  = (emitter_count_i == '0) ||
                    ({{(32-CntCfgW){1'b0}}, emitter_count_i} > 32'(MAX_EMITTERS)) ||
                    (particles_per_flow_i == '0) || (max_particles_i == '0) ||
                    (cmd.active_count > max_particles_i) || (cmd.step_number == '1) ||
                    (started_q && (cmd.step_number != exp_q)) || unwritten;
  assign free_cap = max_particles_i - cmd.active_count;
  assign id_room  = ~next_q;
  assign rate_new = (prod_q[63:32] >> COUNT_BITS) != '0 ? RateMax :
                    RateW'(prod_q >> (32 - FRACTION_BITS));
  // The closing result of an item: always for errors and loads, and for a
  // step only when no emitter produced particles.
  assign final_out = err_q || (cmd.action == ACT_LOAD) || !emitted_q;

  // Any slot in use that was never loaded makes a step invalid.
  always_comb begin
    unwritten = 1'b0;
    for (int i = 0; i < MAX_EMITTERS; i++) begin
      if ((32'(i) < 32'(emitter_count_i)) && !written_q[i]) unwritten = 1'b1;
    end
  end

  // Whether a later slot still has particles to emit in this step.
  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < MAX_EMITTERS; i++) begin
      if ((32'(i) > 32'(ix)) && nz_q[i]) more_after = 1'b1;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i && out_free) begin
          state_d = (cmd.action == ACT_LOAD) ? BK_LOAD_CHK :
                    (pre_bad ? BK_DONE : BK_STEP_ACC);
        end
      end
      BK_LOAD_CHK: begin
        if (!slot_ok || (cmd.start_at > cmd.stop_at) ||
            (idx_q != WalkW'(sl) && written_q[ix] && id_q[ix] == cmd.emitter_id)) begin
          state_d = BK_DONE;
        end else if (idx_q == WalkW'(MAX_EMITTERS - 1)) begin
          state_d = BK_LOAD_MUL;
        end
      end
      BK_LOAD_MUL:  state_d = BK_DONE;
      BK_STEP_ACC: begin
        if (!written_q[ix] || (active && rate_q[ix] == RateMax)) state_d = BK_DONE;
        else if (walk_end) state_d = BK_STEP_CHK;
      end
      BK_STEP_CHK: begin
        state_d = ((total_q > TotW'(free_cap)) || ({{(64-TotW){1'b0}}, total_q} > id_room)) ?
                  BK_DONE : BK_STEP_EMIT;
      end
      BK_STEP_EMIT: begin
        if (out_free && walk_end) state_d = BK_DONE;
      end
      BK_DONE: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs toward the queue.
  always_comb begin
    cmd_pop_o = (state_q == BK_DONE) && out_free;
  end

  // Datapath and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      idx_q     <= '0;
      err_q     <= 1'b0;
      errst_q   <= ST_OK;
      total_q   <= '0;
      started_q <= 1'b0;
      exp_q     <= '0;
      next_q    <= '0;
      emitted_q <= 1'b0;
      ovalid_q  <= 1'b0;
      written_q <= '0;
      nz_q      <= '0;
    end else begin
      state_q <= state_d;
      if (out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        BK_IDLE: begin
          idx_q     <= '0;
          total_q   <= '0;
          emitted_q <= 1'b0;
          nz_q      <= '0;
          err_q     <= (cmd.action == ACT_STEP) && pre_bad;
          errst_q   <= ST_INVALID;
        end
        BK_LOAD_CHK: begin
          idx_q <= idx_q + 1'b1;
          if (state_d == BK_DONE) begin
            err_q   <= 1'b1;
            errst_q <= ST_INVALID;
          end
        end
        BK_LOAD_MUL: begin
          written_q[sl] <= 1'b1;
        end
        BK_STEP_ACC: begin
          idx_q <= idx_q + 1'b1;
          if (!written_q[ix]) begin
            err_q <= 1'b1; errst_q <= ST_INVALID;
          end else if (active && rate_q[ix] == RateMax) begin
            err_q <= 1'b1; errst_q <= ST_CAPACITY;
          end else if (active) begin
            total_q  <= total_q + TotW'(cnt_now);
            nz_q[ix] <= (cnt_now != '0);
          end
          if (walk_end) idx_q <= '0;
        end
        BK_STEP_CHK: begin
          if (state_d == BK_DONE) begin
            err_q <= 1'b1; errst_q <= ST_CAPACITY;
          end
        end
        BK_STEP_EMIT: begin
          if (out_free) begin
            idx_q <= idx_q + 1'b1;
            if (cnt_q[ix] != '0) begin
              ovalid_q  <= 1'b1;
              emitted_q <= 1'b1;
              next_q    <= next_q + 64'(cnt_q[ix]);
            end
          end
        end
        BK_DONE: begin
          if (out_free) begin
            if (final_out) ovalid_q <= 1'b1;
            if (!err_q && (cmd.action == ACT_STEP)) begin
              started_q <= 1'b1;
              exp_q     <= cmd.step_number + 32'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Table writes and result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == BK_IDLE) prod_q <= 64'(cmd.flow) * 64'(particles_per_flow_i);
    if (state_q == BK_LOAD_MUL) begin
      if (written_q[sl] && id_q[sl] != cmd.emitter_id) carry_q[sl] <= '0;
      id_q[sl]    <= cmd.emitter_id;
      start_q[sl] <= cmd.start_at;
      stop_q[sl]  <= cmd.stop_at;
      rate_q[sl]  <= rate_new;
    end
    if (state_q == BK_STEP_ACC && written_q[ix]) begin
      newc_q[ix] <= active ? fsum[FRACTION_BITS-1:0] : cin;
      cnt_q[ix]  <= active ? cnt_now : '0;
    end
    if (state_q == BK_STEP_CHK && state_d == BK_STEP_EMIT) begin
      for (int i = 0; i < MAX_EMITTERS; i++) begin
        if (32'(i) < 32'(emitter_count_i)) carry_q[i] <= newc_q[i];
        else if (!started_q) carry_q[i] <= '0;
      end
    end
    if (state_q == BK_STEP_EMIT && out_free && cnt_q[ix] != '0) begin
      out_q.status         <= ST_OK;
      out_q.source_id      <= id_q[ix];
      out_q.particle_count <= MaxPartW'(cnt_q[ix]);
      out_q.first_particle <= next_q;
      out_q.last           <= !more_after;
    end
    if (state_q == BK_DONE && out_free && final_out) begin
      out_q.last           <= 1'b1;
      out_q.particle_count <= '0;
      if (err_q) begin
        out_q.status         <= errst_q;
        out_q.source_id      <= (cmd.action == ACT_LOAD) ? cmd.emitter_id : '0;
        out_q.first_particle <= '0;
      end else if (cmd.action == ACT_LOAD) begin
        out_q.status         <= ST_OK;
        out_q.source_id      <= cmd.emitter_id;
        out_q.first_particle <= '0;
      end else begin
        out_q.status         <= ST_OK;
        out_q.source_id      <= '0;
        out_q.first_particle <= next_q;
      end
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;
endmodule

// ===== rtl/core/mcfre_checker.sv =====
// ---------------------------------------------------------------------------
// mcfre_checker: port-level checks on the emitter's result channel.
// Bound to the top level.
// ---------------------------------------------------------------------------
module mcfre_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid,
  input logic               out_ready,
  input mcfre_pkg::out_item_t out_data
);
  import mcfre_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Errors are always single final results with no particles.
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.status != ST_OK |-> out_data.last && out_data.particle_count == '0)
    else $error("error result malformed");

  // Status never takes the unused code.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");
endmodule

bind multi_channel_fractional_rate_emitter_core mcfre_checker u_chk (
  .clk_i, .rst_ni,
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);

// ===== dv/multi_channel_fractional_rate_emitter_core_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Testbench for multi_channel_fractional_rate_emitter_core.
// A directed sequence covers the checks on loads and steps and the extreme
// register values. Randomized load/step traffic then follows under three
// handshake idling profiles. Every result transfer is checked against a predictor.
// ---------------------------------------------------------------------------
module multi_channel_fractional_rate_emitter_core_tb;
  import mcfre_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned Limit    = 400000;
  localparam logic [35:0] RateSat  = '1;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  mcfre_if #(.T(in_item_t))  in_ch ();
  mcfre_if #(.T(out_item_t)) out_ch ();

  multi_channel_fractional_rate_emitter_core u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  // Shadow registers and emitter table of the predictor.
  logic [20:0] max_part;
  logic [31:0] ppf;
  logic [4:0]  emit_cnt;
  logic [31:0] slot_id    [NumSlots];
  logic [31:0] slot_start [NumSlots];
  logic [31:0] slot_stop  [NumSlots];
  logic [35:0] slot_rate  [NumSlots];
  logic [15:0] slot_carry [NumSlots];
  bit          slot_loaded[NumSlots];
  bit          running;
  logic [31:0] exp_step;
  logic [63:0] next_pid;

  in_item_t  pending_items[$];
  out_item_t emission_q[$];
  int unsigned src_idle;
  int unsigned snk_idle;
  int unsigned fail_cnt;
  int unsigned cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void expect_result(logic [1:0] st, logic [31:0] src, logic [20:0] cnt,
                                        logic [63:0] first, logic lst);
    out_item_t r;
    r.status         = st;
    r.source_id      = src;
    r.particle_count = cnt;
    r.first_particle = first;
    r.last           = lst;
    emission_q.insert(emission_q.size(), r);
  endfunction

  // Load of one slot: rate is flow times the scale, truncated to Q20.16 and saturated on overflow.
  function automatic void apply_load(in_item_t it);
    logic [63:0] prod;
    logic [35:0] rate;
    int unsigned s;
    s = 32'(it.slot);
    if (it.start_at > it.stop_at) begin
      expect_result(ST_INVALID, it.emitter_id, '0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < NumSlots; i++) begin
      if (i != s && slot_loaded[i] && slot_id[i] == it.emitter_id) begin
        expect_result(ST_INVALID, it.emitter_id, '0, '0, 1'b1);
        return;
      end
    end
    prod = 64'(it.flow) * 64'(ppf);
    rate = (prod[63:52] != 0) ? RateSat : prod[51:16];
    if (slot_loaded[s] && slot_id[s] != it.emitter_id) slot_carry[s] = '0;
    slot_id[s]     = it.emitter_id;
    slot_start[s]  = it.start_at;
    slot_stop[s]   = it.stop_at;
    slot_rate[s]   = rate;
    slot_loaded[s] = 1'b1;
    expect_result(ST_OK, it.emitter_id, '0, '0, 1'b1);
  endfunction

  // One solver step: accumulate carries, then hand out particle ids in slot order.
  function automatic void apply_step(in_item_t it);
    logic [63:0] cnt[NumSlots];
    logic [15:0] nc[NumSlots];
    logic [63:0] total;
    logic [16:0] f;
    logic [15:0] c;
    int unsigned n;
    int unsigned k;
    n = 32'(emit_cnt);
    total = '0;
    k = 0;
    if (n == 0 || n > NumSlots || ppf == 0 || max_part == 0 || it.active_count > max_part ||
        it.step_number == '1 || (running && it.step_number != exp_step)) begin
      expect_result(ST_INVALID, '0, '0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (!slot_loaded[i]) begin
        expect_result(ST_INVALID, '0, '0, '0, 1'b1);
        return;
      end
    end
    for (int i = 0; i < n; i++) begin
      c = running ? slot_carry[i] : '0;
      cnt[i] = '0;
      nc[i] = c;
      if (it.step_number >= slot_start[i] && it.step_number < slot_stop[i]) begin
        if (slot_rate[i] == RateSat) begin
          expect_result(ST_CAPACITY, '0, '0, '0, 1'b1);
          return;
        end
        f = 17'(slot_rate[i][15:0]) + 17'(c);
        cnt[i] = 64'(slot_rate[i][35:16]) + 64'(f[16]);
        nc[i] = f[15:0];
        total = total + cnt[i];
      end
    end
    if (total > 64'(max_part - it.active_count) || total > ~next_pid) begin
      expect_result(ST_CAPACITY, '0, '0, '0, 1'b1);
      return;
    end
    if (!running) begin
      for (int i = 0; i < NumSlots; i++) slot_carry[i] = '0;
    end
    for (int i = 0; i < n; i++) slot_carry[i] = nc[i];
    for (int i = 0; i < n; i++) begin
      if (cnt[i] != 0) begin
        expect_result(ST_OK, slot_id[i], cnt[i][20:0], next_pid, 1'b0);
        next_pid = next_pid + cnt[i];
        k++;
      end
    end
    if (k == 0) expect_result(ST_OK, '0, '0, next_pid, 1'b1);
    else emission_q[emission_q.size()-1].last = 1'b1;
    exp_step = it.step_number + 32'd1;
    running = 1'b1;
  endfunction

  // Driver: presents queued items and randomizes the result-side ready.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid  <= 1'b0;
      in_ch.data   <= '0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= src_idle) begin
          in_ch.valid <= 1'b1;
          in_ch.data  <= pending_items.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // Monitor: predicts on each input transfer and checks each result transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.data.action == ACT_LOAD) apply_load(in_ch.data);
        else apply_step(in_ch.data);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (emission_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) $display("unexpected result: %p", out_ch.data);
        end else begin
          if (out_ch.data.status !== emission_q[0].status ||
              out_ch.data.source_id !== emission_q[0].source_id ||
              out_ch.data.particle_count !== emission_q[0].particle_count ||
              out_ch.data.first_particle !== emission_q[0].first_particle ||
              out_ch.data.last !== emission_q[0].last) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: expected %p, actual %p", emission_q[0], out_ch.data);
          end
          void'(emission_q.pop_front());
        end
      end
      cycles++;
      if (cycles == Limit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Hands over one item once the previous one has been taken, so the
  // generator sees the predictor state that the item will meet.
  task automatic queue_item(in_item_t it);
    while (pending_items.size() != 0 || in_ch.valid) @(negedge clk_i);
    pending_items.insert(pending_items.size(), it);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_ch.valid || emission_q.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MAX_PART: max_part = val[20:0];
      REG_PPF:      ppf = val;
      default:      emit_cnt = val[4:0];
    endcase
    @(negedge clk_i);
  endtask

  function automatic in_item_t load_item(logic [3:0] s, logic [31:0] id, logic [31:0] st,
                                         logic [31:0] sp, logic [31:0] fl);
    in_item_t it;
    it = '0;
    it.action     = ACT_LOAD;
    it.slot       = s;
    it.emitter_id = id;
    it.start_at   = st;
    it.stop_at    = sp;
    it.flow       = fl;
    it.step_number  = $urandom();
    it.active_count = 21'($urandom());
    return it;
  endfunction

  function automatic in_item_t step_item(logic [31:0] stp, logic [20:0] act);
    in_item_t it;
    it = '0;
    it.action       = ACT_STEP;
    it.slot         = 4'($urandom());
    it.emitter_id   = $urandom();
    it.flow         = $urandom();
    it.step_number  = stp;
    it.active_count = act;
    return it;
  endfunction

  // Random item: mostly loads near the current step and in-sequence steps.
  function automatic in_item_t random_item();
    logic [3:0]  s;
    logic [31:0] id;
    logic [31:0] st;
    logic [31:0] sp;
    logic [31:0] fl;
    logic [31:0] stp;
    logic [20:0] act;
    int unsigned j;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 30) begin
      s  = 4'($urandom());
      id = $urandom();
      j  = $urandom_range(NumSlots - 1);
      if ($urandom_range(19) == 0 && slot_loaded[j]) id = slot_id[j];
      st = exp_step - $urandom_range(3);
      sp = st + $urandom_range(1, 40);
      if ($urandom_range(9) == 0) begin
        st = $urandom();
        sp = $urandom();
      end
      fl = $urandom_range(32'h0008_0000);
      if ($urandom_range(19) == 0) fl = $urandom();
      return load_item(s, id, st, sp, fl);
    end
    stp = running ? exp_step : $urandom_range(20);
    act = 21'($urandom_range(32'(max_part / 2)));
    if ($urandom_range(15) == 0) stp = $urandom_range(1) ? 32'hFFFF_FFFF : $urandom();
    if ($urandom_range(19) == 0) act = 21'($urandom());
    return step_item(stp, act);
  endfunction

  task automatic random_phase(int unsigned n_items, int unsigned s_idle, int unsigned r_idle);
    src_idle = s_idle;
    snk_idle = r_idle;
    for (int i = 0; i < n_items; i++) queue_item(random_item());
  endtask

  // Stimulus.
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    src_idle = 18;
    snk_idle = 79;
    fail_cnt = 0;
    cycles   = 0;
    max_part = 21'd65536;
    ppf      = '0;
    emit_cnt = '0;
    for (int i = 0; i < NumSlots; i++) begin
      slot_loaded[i] = 1'b0;
      slot_carry[i]  = '0;
    end
    running   = 1'b0;
    exp_step  = '0;
    next_pid  = '0;
    repeat (3) @(posedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: register checks, load rejections, step checks, saturation.
    queue_item(step_item(32'd0, 21'd0));
    write_reg(REG_EMIT_CNT, 32'd31);
    queue_item(step_item(32'd0, 21'd0));
    write_reg(REG_PPF, 32'd1);
    write_reg(REG_EMIT_CNT, 32'd2);
    queue_item(step_item(32'd0, 21'd0));
    queue_item(load_item(4'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_item(load_item(4'd15, 32'hFFFF_FFFF, 32'd5, 32'd3, 32'd7));
    queue_item(load_item(4'd15, 32'h0, 32'h0, 32'h0, 32'h0));
    queue_item(load_item(4'd1, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
    write_reg(REG_PPF, 32'h0001_8000);
    queue_item(load_item(4'd1, 32'hFFFF_FFFF, 32'd1, 32'd10, 32'h0001_0000));
    write_reg(REG_MAX_PART, 32'd0);
    queue_item(step_item(32'd0, 21'd0));
    write_reg(REG_MAX_PART, 32'd1048576);
    queue_item(step_item(32'hFFFF_FFFF, 21'd1048576));
    queue_item(step_item(32'd0, 21'h1F_FFFF));
    queue_item(step_item(32'd0, 21'd0));
    queue_item(step_item(32'd5, 21'd0));
    queue_item(step_item(32'd1, 21'd1048576));
    queue_item(step_item(32'd1, 21'd1048574));
    queue_item(load_item(4'd0, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_item(step_item(32'd2, 21'd0));
    write_reg(REG_PPF, 32'hFFFF_FFFF);
    queue_item(load_item(4'd0, 32'h1234_5678, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    queue_item(step_item(32'd3, 21'd0));

    // Random: all slots in use, wide capacity.
    write_reg(REG_PPF, 32'h0001_8000);
    write_reg(REG_EMIT_CNT, 32'd16);
    for (int i = 0; i < NumSlots; i++)
      queue_item(load_item(4'(i), 32'hA000_0000 + 32'(i), exp_step, exp_step + 32'd200,
                           $urandom_range(32'h0004_0000)));
    random_phase(75, 18, 79);

    // Random: small capacity and a low scale, roles of the idling swapped.
    write_reg(REG_MAX_PART, 32'd2000);
    write_reg(REG_PPF, 32'h0000_4000);
    write_reg(REG_EMIT_CNT, 32'd7);
    random_phase(85, 79, 18);

    // Random: no idling on either side.
    write_reg(REG_MAX_PART, 32'd65536);
    write_reg(REG_PPF, 32'h0003_0000);
    write_reg(REG_EMIT_CNT, 32'd12);
    random_phase(80, 0, 0);

    // Drain and let the last step finish.
    while (pending_items.size() != 0 || in_ch.valid || emission_q.size() != 0)
      @(negedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mcfre_pkg.sv
rtl/core/mcfre_if.sv
rtl/core/mcfre_front.sv
rtl/core/mcfre_back.sv
rtl/core/multi_channel_fractional_rate_emitter_core.sv
rtl/core/mcfre_checker.sv
dv/multi_channel_fractional_rate_emitter_core_tb.sv
